// ===== design/parallelepiped_ray_entry_distance_assert.svh =====
// assertion macros for the ray entry distance block
`ifndef PARALLELEPIPED_RAY_ENTRY_DISTANCE_ASSERT_SVH
`define PARALLELEPIPED_RAY_ENTRY_DISTANCE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PRED_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PRED_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pred_pkg.sv =====
// shared types, widths and helpers for the ray entry distance block
package pred_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int DIR_W   = 32;
    localparam int NORM_W  = 32;
    localparam int HZ_W    = 31;
    localparam int DIST_W  = 31;
    localparam int PROD_W  = 64;
    localparam int SUM_W   = 66;
    localparam int DOT_W   = 36;
    localparam int DIS_W   = 37;
    localparam int Q_FRAC  = 30;
    localparam int NPLANE  = 4;
    localparam int NDIV    = 6;

    // divider operand widths and latency
    localparam int NUM_W   = 34;
    localparam int DEN_W   = 36;
    localparam int T_W     = NUM_W + Q_FRAC;
    localparam int DIV_LAT = (NUM_W - 1) + Q_FRAC + 2;

    // half surface tolerance in lsb
    localparam int HALF_TOLERANCE = 1;

    localparam longint NUM_LIMIT = (64'sd1 <<< (NUM_W - 1)) - 64'sd1;
    localparam logic signed [T_W-1:0] T_NEG_INF = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_POS_INF = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] DIST_MAX_T = {{(T_W-DIST_W){1'b0}}, {DIST_W{1'b1}}};

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_Y_NORM_B = 3'd0,
        CFG_Y_NORM_C = 3'd1,
        CFG_Y_OFFSET = 3'd2,
        CFG_X_NORM_A = 3'd3,
        CFG_X_NORM_B = 3'd4,
        CFG_X_NORM_C = 3'd5,
        CFG_X_OFFSET = 3'd6,
        CFG_HALF_Z   = 3'd7
    } cfg_idx_t;

    // how a plane bounds the interval
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_ENTRY,
        CLS_EXIT
    } plane_cls_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
    } ray_word_t;

    typedef struct packed {
        logic              hit;
        logic [DIST_W-1:0] distance;
    } result_word_t;

    // status carried alongside the dividers
    typedef struct packed {
        logic                    miss;
        logic                    zinf;
        plane_cls_t [NPLANE-1:0] cls;
    } side_t;

    function automatic logic signed [T_W-1:0] t_max(
        input logic signed [T_W-1:0] a,
        input logic signed [T_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [T_W-1:0] t_min(
        input logic signed [T_W-1:0] a,
        input logic signed [T_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== design/pred_stream_if.sv =====
// valid/ready stream interface carrying one word
interface pred_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pred_div.sv =====
// pipelined restoring divider, one quotient bit per stage, truncating
module pred_div #(
    parameter int NUM_W  = pred_pkg::NUM_W,
    parameter int DEN_W  = pred_pkg::DEN_W,
    parameter int FRAC_W = pred_pkg::Q_FRAC
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [NUM_W-1:0]          num,
    input  logic signed [DEN_W-1:0]          den,
    output logic signed [NUM_W+FRAC_W-1:0]   quo
);
    localparam int MAG_W = NUM_W - 1;
    localparam int Q_W   = MAG_W + FRAC_W;

    logic [Q_W-1:0]   dq_reg   [Q_W+1];
    logic [DEN_W-1:0] rem_reg  [Q_W+1];
    logic [DEN_W-1:0] dmag_reg [Q_W+1];
    logic             neg_reg  [Q_W+1];
    logic [Q_W-1:0]   dq_next   [Q_W+1];
    logic [DEN_W-1:0] rem_next  [Q_W+1];
    logic [DEN_W-1:0] dmag_next [Q_W+1];
    logic             neg_next  [Q_W+1];
    logic [DEN_W:0]   trial [Q_W];
    logic             ge    [Q_W];
    logic [MAG_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic signed [Q_W:0] quo_next;
    logic signed [Q_W:0] quo_reg;

    // operand magnitudes and quotient sign, then one restoring step per stage:
    // dividend bits shift out, quotient bits shift in
    always_comb
    begin
        num_mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
        den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        dq_next[0]   = {num_mag, {FRAC_W{1'b0}}};
        rem_next[0]  = '0;
        dmag_next[0] = den_mag;
        neg_next[0]  = num[NUM_W-1] ^ den[DEN_W-1];
        for (int k = 0; k < Q_W; k++)
        begin
            trial[k] = {rem_reg[k], dq_reg[k][Q_W-1]};
            ge[k]    = trial[k] >= {1'b0, dmag_reg[k]};
            rem_next[k+1]  = ge[k] ? DEN_W'(trial[k] - {1'b0, dmag_reg[k]})
                                   : trial[k][DEN_W-1:0];
            dq_next[k+1]   = {dq_reg[k][Q_W-2:0], ge[k]};
            dmag_next[k+1] = dmag_reg[k];
            neg_next[k+1]  = neg_reg[k];
        end
    end

    // apply sign
    always_comb
    begin
        quo_next = neg_reg[Q_W] ? -$signed({1'b0, dq_reg[Q_W]}) : $signed({1'b0, dq_reg[Q_W]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= Q_W; k++)
            begin
                dq_reg[k]   <= dq_next[k];
                rem_reg[k]  <= rem_next[k];
                dmag_reg[k] <= dmag_next[k];
                neg_reg[k]  <= neg_next[k];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ===== design/parallelepiped_ray_entry_distance.sv =====
// top level: ray entry distance into a skewed parallelepiped
// One ray word is taken per clock while the pipeline is not stalled, and one result
// word comes out per ray, in order: products, dot sums and plane setup in the front
// stages, six parallel restoring dividers (63 quotient bits, one bit per stage)
// that form the crossing distances, and back stages that clip the interval and
// saturate the distance. The pipeline moves as a whole: while the output word is
// not taken every stage holds and ray.ready is low; with a free output it is high.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata while no
// ray is in flight; the user is bound to this, the block itself does not enforce it.
`include "parallelepiped_ray_entry_distance_assert.svh"
module parallelepiped_ray_entry_distance (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  pred_pkg::cfg_idx_t  cfg_index,
    input  logic [31:0]         cfg_wdata,
    pred_stream_if.sink         ray,
    pred_stream_if.source       result
);
    import pred_pkg::*;

    localparam int ST_DIVOUT = 4 + DIV_LAT;
    localparam int ST_OUT    = ST_DIVOUT + 3;
    localparam int NSTG      = ST_OUT + 1;

    // configuration registers
    logic signed [NORM_W-1:0] y_norm_b_reg, y_norm_c_reg;
    logic signed [NORM_W-1:0] x_norm_a_reg, x_norm_b_reg, x_norm_c_reg;
    logic signed [POS_W-1:0]  y_offset_reg, x_offset_reg;
    logic [HZ_W-1:0]          half_z_reg;

    logic            adv;
    logic [NSTG-1:0] vld_reg;

    // stage registers
    ray_word_t                s0_ray_reg;
    logic signed [PROD_W-1:0] s1_yv1_reg, s1_yv2_reg, s1_yp1_reg, s1_yp2_reg;
    logic signed [PROD_W-1:0] s1_xv0_reg, s1_xv1_reg, s1_xv2_reg;
    logic signed [PROD_W-1:0] s1_xp0_reg, s1_xp1_reg, s1_xp2_reg;
    logic                     s1_zmiss_reg, s1_zinf_reg;
    logic signed [NUM_W-1:0]  s1_zn1_reg, s1_zn2_reg;
    logic signed [DIR_W-1:0]  s1_vz_reg;
    logic signed [DOT_W-1:0]  s2_cy_reg, s2_dy_reg, s2_cx_reg, s2_dx_reg;
    logic                     s2_zmiss_reg, s2_zinf_reg;
    logic signed [NUM_W-1:0]  s2_zn1_reg, s2_zn2_reg;
    logic signed [DIR_W-1:0]  s2_vz_reg;
    logic signed [DIS_W-1:0]  s3_dis_reg [NPLANE];
    logic signed [DOT_W-1:0]  s3_cos_reg [NPLANE];
    logic                     s3_zmiss_reg, s3_zinf_reg;
    logic signed [NUM_W-1:0]  s3_zn1_reg, s3_zn2_reg;
    logic signed [DIR_W-1:0]  s3_vz_reg;
    logic signed [NUM_W-1:0]  s4_num_reg [NDIV];
    logic signed [DEN_W-1:0]  s4_den_reg [NDIV];
    side_t                    s4_side_reg;
    side_t                    side_reg [DIV_LAT];
    logic signed [T_W-1:0]    p1_lo_reg [3];
    logic signed [T_W-1:0]    p1_hi_reg [3];
    logic                     p1_miss_reg;
    logic signed [T_W-1:0]    p2_tmin_reg, p2_tmax_reg;
    logic                     p2_miss_reg;
    result_word_t             out_reg;

    // combinational next values
    logic signed [33:0]       az;
    logic signed [34:0]       z_gap;
    logic signed [NUM_W-1:0]  pz, hz;
    logic                     zheads;
    logic                     s1_zmiss_next;
    logic signed [NUM_W-1:0]  s1_zn1_next, s1_zn2_next;
    logic signed [SUM_W-1:0]  sum_cy, sum_dy, sum_cx, sum_dx;
    logic signed [DIS_W:0]    neg_dis [NPLANE];
    logic signed [NUM_W-1:0]  s4_num_next [NDIV];
    logic signed [DEN_W-1:0]  s4_den_next [NDIV];
    side_t                    s4_side_next;
    logic signed [T_W-1:0]    div_q [NDIV];
    side_t                    side_out;
    logic signed [T_W-1:0]    lo [5];
    logic signed [T_W-1:0]    hi [5];
    logic                     ok;
    logic [DIST_W-1:0]        dist_next;
    result_word_t             out_next;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_norm_b_reg <= -32'sd1073741824;
            y_norm_c_reg <= '0;
            y_offset_reg <= -32'sd65536;
            x_norm_a_reg <= -32'sd1073741824;
            x_norm_b_reg <= '0;
            x_norm_c_reg <= '0;
            x_offset_reg <= -32'sd65536;
            half_z_reg   <= 31'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_Y_NORM_B: y_norm_b_reg <= $signed(cfg_wdata);
                CFG_Y_NORM_C: y_norm_c_reg <= $signed(cfg_wdata);
                CFG_Y_OFFSET: y_offset_reg <= $signed(cfg_wdata);
                CFG_X_NORM_A: x_norm_a_reg <= $signed(cfg_wdata);
                CFG_X_NORM_B: x_norm_b_reg <= $signed(cfg_wdata);
                CFG_X_NORM_C: x_norm_c_reg <= $signed(cfg_wdata);
                CFG_X_OFFSET: x_offset_reg <= $signed(cfg_wdata);
                CFG_HALF_Z:   half_z_reg   <= cfg_wdata[HZ_W-1:0];
                default:      ;
            endcase
        end
    end

    // whole pipeline advances when the output word is free or taken
    assign adv       = !vld_reg[ST_OUT] || result.ready;
    assign ray.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], ray.valid};
        end
    end

    // z slab: outside test and both crossing numerators
    always_comb
    begin
        pz     = NUM_W'(s0_ray_reg.pos_z);
        hz     = NUM_W'($signed({1'b0, half_z_reg}));
        az     = s0_ray_reg.pos_z[POS_W-1] ? -34'(s0_ray_reg.pos_z) : 34'(s0_ray_reg.pos_z);
        z_gap  = 35'(az) - 35'(hz);
        zheads = (s0_ray_reg.pos_z < 0 && s0_ray_reg.dir_z > 0)
              || (s0_ray_reg.pos_z > 0 && s0_ray_reg.dir_z < 0);
        s1_zmiss_next = (z_gap >= -35'(HALF_TOLERANCE)) && !zheads;
        if (s0_ray_reg.dir_z > 0)
        begin
            s1_zn1_next = -pz - hz;
            s1_zn2_next = -pz + hz;
        end
        else
        begin
            s1_zn1_next = -pz + hz;
            s1_zn2_next = -pz - hz;
        end
    end

    // exact dot sums, floored once
    always_comb
    begin
        sum_cy = SUM_W'(s1_yv1_reg) + SUM_W'(s1_yv2_reg);
        sum_dy = SUM_W'(s1_yp1_reg) + SUM_W'(s1_yp2_reg);
        sum_cx = SUM_W'(s1_xv0_reg) + SUM_W'(s1_xv1_reg) + SUM_W'(s1_xv2_reg);
        sum_dx = SUM_W'(s1_xp0_reg) + SUM_W'(s1_xp1_reg) + SUM_W'(s1_xp2_reg);
    end

    // plane classes and clamped numerators
    always_comb
    begin
        s4_side_next.zinf = s3_zinf_reg;
        s4_side_next.miss = s3_zmiss_reg;
        s4_num_next[0] = s3_zn1_reg;
        s4_num_next[1] = s3_zn2_reg;
        s4_den_next[0] = DEN_W'(s3_vz_reg);
        s4_den_next[1] = DEN_W'(s3_vz_reg);
        for (int i = 0; i < NPLANE; i++)
        begin
            neg_dis[i] = -(DIS_W+1)'(s3_dis_reg[i]);
            if (s3_dis_reg[i] >= -DIS_W'(HALF_TOLERANCE))
            begin
                if (s3_cos_reg[i] >= 0)
                begin
                    s4_side_next.miss   = 1'b1;
                    s4_side_next.cls[i] = CLS_NONE;
                end
                else
                begin
                    s4_side_next.cls[i] = CLS_ENTRY;
                end
            end
            else if (s3_cos_reg[i] > 0)
            begin
                s4_side_next.cls[i] = CLS_EXIT;
            end
            else
            begin
                s4_side_next.cls[i] = CLS_NONE;
            end
            if (neg_dis[i] > (DIS_W+1)'(NUM_LIMIT))
                s4_num_next[i+2] = NUM_W'(NUM_LIMIT);
            else if (neg_dis[i] < -(DIS_W+1)'(NUM_LIMIT))
                s4_num_next[i+2] = -NUM_W'(NUM_LIMIT);
            else
                s4_num_next[i+2] = NUM_W'(neg_dis[i]);
            s4_den_next[i+2] = DEN_W'(s3_cos_reg[i]);
        end
    end

    // front stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_ray_reg <= ray.data;

            s1_yv1_reg <= PROD_W'(y_norm_b_reg) * PROD_W'(s0_ray_reg.dir_y);
            s1_yv2_reg <= PROD_W'(y_norm_c_reg) * PROD_W'(s0_ray_reg.dir_z);
            s1_yp1_reg <= PROD_W'(y_norm_b_reg) * PROD_W'(s0_ray_reg.pos_y);
            s1_yp2_reg <= PROD_W'(y_norm_c_reg) * PROD_W'(s0_ray_reg.pos_z);
            s1_xv0_reg <= PROD_W'(x_norm_a_reg) * PROD_W'(s0_ray_reg.dir_x);
            s1_xv1_reg <= PROD_W'(x_norm_b_reg) * PROD_W'(s0_ray_reg.dir_y);
            s1_xv2_reg <= PROD_W'(x_norm_c_reg) * PROD_W'(s0_ray_reg.dir_z);
            s1_xp0_reg <= PROD_W'(x_norm_a_reg) * PROD_W'(s0_ray_reg.pos_x);
            s1_xp1_reg <= PROD_W'(x_norm_b_reg) * PROD_W'(s0_ray_reg.pos_y);
            s1_xp2_reg <= PROD_W'(x_norm_c_reg) * PROD_W'(s0_ray_reg.pos_z);
            s1_zmiss_reg <= s1_zmiss_next;
            s1_zinf_reg  <= (s0_ray_reg.dir_z == 0);
            s1_zn1_reg   <= s1_zn1_next;
            s1_zn2_reg   <= s1_zn2_next;
            s1_vz_reg    <= s0_ray_reg.dir_z;

            s2_cy_reg    <= DOT_W'(sum_cy >>> Q_FRAC);
            s2_dy_reg    <= DOT_W'(sum_dy >>> Q_FRAC);
            s2_cx_reg    <= DOT_W'(sum_cx >>> Q_FRAC);
            s2_dx_reg    <= DOT_W'(sum_dx >>> Q_FRAC);
            s2_zmiss_reg <= s1_zmiss_reg;
            s2_zinf_reg  <= s1_zinf_reg;
            s2_zn1_reg   <= s1_zn1_reg;
            s2_zn2_reg   <= s1_zn2_reg;
            s2_vz_reg    <= s1_vz_reg;

            // second plane of a pair: negated cosine, offset minus distance
            s3_dis_reg[0] <= DIS_W'(y_offset_reg) + DIS_W'(s2_dy_reg);
            s3_dis_reg[1] <= DIS_W'(y_offset_reg) - DIS_W'(s2_dy_reg);
            s3_dis_reg[2] <= DIS_W'(x_offset_reg) + DIS_W'(s2_dx_reg);
            s3_dis_reg[3] <= DIS_W'(x_offset_reg) - DIS_W'(s2_dx_reg);
            s3_cos_reg[0] <= s2_cy_reg;
            s3_cos_reg[1] <= -s2_cy_reg;
            s3_cos_reg[2] <= s2_cx_reg;
            s3_cos_reg[3] <= -s2_cx_reg;
            s3_zmiss_reg  <= s2_zmiss_reg;
            s3_zinf_reg   <= s2_zinf_reg;
            s3_zn1_reg    <= s2_zn1_reg;
            s3_zn2_reg    <= s2_zn2_reg;
            s3_vz_reg     <= s2_vz_reg;

            for (int i = 0; i < NDIV; i++)
            begin
                s4_num_reg[i] <= s4_num_next[i];
                s4_den_reg[i] <= s4_den_next[i];
            end
            s4_side_reg <= s4_side_next;
        end
    end

    // crossing distances: z entry, z exit, then the four side planes
    for (genvar g = 0; g < NDIV; g++)
    begin : g_div
        pred_div #(
            .NUM_W  (NUM_W),
            .DEN_W  (DEN_W),
            .FRAC_W (Q_FRAC)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (s4_num_reg[g]),
            .den (s4_den_reg[g]),
            .quo (div_q[g])
        );
    end

    // status delay line matching the divider latency
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= s4_side_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign side_out = side_reg[DIV_LAT-1];

    // interval bound candidates
    always_comb
    begin
        lo[0] = side_out.zinf ? T_NEG_INF : div_q[0];
        hi[0] = side_out.zinf ? T_POS_INF : div_q[1];
        for (int i = 0; i < NPLANE; i++)
        begin
            lo[i+1] = (side_out.cls[i] == CLS_ENTRY) ? div_q[i+2] : T_NEG_INF;
            hi[i+1] = (side_out.cls[i] == CLS_EXIT)  ? div_q[i+2] : T_POS_INF;
        end
    end

    // final test and saturation
    always_comb
    begin
        ok = !p2_miss_reg
          && !((T_W+2)'(p2_tmax_reg) <= (T_W+2)'(p2_tmin_reg) + (T_W+2)'(HALF_TOLERANCE));
        if (p2_tmin_reg < T_W'(HALF_TOLERANCE))
            dist_next = '0;
        else if (p2_tmin_reg > DIST_MAX_T)
            dist_next = '1;
        else
            dist_next = p2_tmin_reg[DIST_W-1:0];
        out_next.hit      = ok;
        out_next.distance = ok ? dist_next : '0;
    end

    // back stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_lo_reg[0] <= t_max(lo[0], lo[1]);
            p1_lo_reg[1] <= t_max(lo[2], lo[3]);
            p1_lo_reg[2] <= lo[4];
            p1_hi_reg[0] <= t_min(hi[0], hi[1]);
            p1_hi_reg[1] <= t_min(hi[2], hi[3]);
            p1_hi_reg[2] <= hi[4];
            p1_miss_reg  <= side_out.miss;

            p2_tmin_reg <= t_max(t_max(p1_lo_reg[0], p1_lo_reg[1]), p1_lo_reg[2]);
            p2_tmax_reg <= t_min(t_min(p1_hi_reg[0], p1_hi_reg[1]), p1_hi_reg[2]);
            p2_miss_reg <= p1_miss_reg;

            out_reg <= out_next;
        end
    end

    assign result.valid = vld_reg[ST_OUT];
    assign result.data  = out_reg;

    // checks
    `PRED_ASSERT_IMP(a_miss_zero, result.valid && !result.data.hit, result.data.distance == '0, "miss word carries a distance")
    `PRED_ASSERT_NXT(a_stall_hold, !adv, $stable(vld_reg), "pipeline moved during a stall")
    `PRED_ASSERT_NXT(a_accept_enters, ray.valid && ray.ready, vld_reg[0], "accepted ray not in first stage")
    `PRED_ASSERT_IMP(a_free_ready, !result.valid, ray.ready, "input blocked with empty output")

endmodule

// ===== sim/tb.sv =====
// testbench for the parallelepiped ray entry distance block
`timescale 1ns / 100ps
module tb;
    import pred_pkg::*;

    localparam int DRAIN_CYCLES = 90;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [31:0] cfg_wdata;

    pred_stream_if #(.word_t(ray_word_t))    ray_if ();
    pred_stream_if #(.word_t(result_word_t)) res_if ();

    parallelepiped_ray_entry_distance u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ray       (ray_if.sink),
        .result    (res_if.source)
    );

    // shadow copy of the registers and pending results
    logic [31:0]  shadow_regs [8];
    result_word_t pending_hits [$];
    int           mismatches;
    bit           idle_on;
    bit           hold_long;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // generous run bound
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // floor(sum a*b / 2^30), exact
    function automatic longint dot_q30(longint a0, longint a1, longint a2,
                                       longint b0, longint b1, longint b2);
        logic signed [127:0] x0, x1, x2, y0, y1, y2, s;
        x0 = a0; x1 = a1; x2 = a2;
        y0 = b0; y1 = b1; y2 = b2;
        s = x0 * y0 + x1 * y1 + x2 * y2;
        return longint'(s >>> 30);
    endfunction

    // crossing parameter with saturated numerator
    function automatic longint cross_t(longint num, longint den);
        longint lim;
        lim = (longint'(1) <<< 33) - 1;
        if (num > lim) num = lim;
        if (num < -lim) num = -lim;
        if (den == 0)
            return 0;
        return (num * (longint'(1) <<< 30)) / den;
    endfunction

    // narrow the interval by one plane, zero on miss
    function automatic bit clip_face(longint dis, longint cosv,
                                     inout longint tmin, inout longint tmax);
        longint t;
        if (dis >= -HALF_TOLERANCE)
        begin
            if (cosv >= 0)
                return 1'b0;
            t = cross_t(-dis, cosv);
            if (tmin < t) tmin = t;
        end
        else if (cosv > 0)
        begin
            t = cross_t(-dis, cosv);
            if (tmax > t) tmax = t;
        end
        return 1'b1;
    endfunction

    // expected entry distance for one ray
    function automatic result_word_t entry_distance(ray_word_t r);
        longint px, py, pz, vx, vy, vz, hz, yoff, xoff, tmin, tmax;
        longint az, dz, cy, dy, cx, dx, d;
        longint ynb, ync, xna, xnb, xnc;
        bit ok;
        result_word_t res;
        px = r.pos_x; py = r.pos_y; pz = r.pos_z;
        vx = r.dir_x; vy = r.dir_y; vz = r.dir_z;
        hz = {33'd0, shadow_regs[CFG_HALF_Z][30:0]};
        yoff = $signed(shadow_regs[CFG_Y_OFFSET]);
        xoff = $signed(shadow_regs[CFG_X_OFFSET]);
        ynb = $signed(shadow_regs[CFG_Y_NORM_B]);
        ync = $signed(shadow_regs[CFG_Y_NORM_C]);
        xna = $signed(shadow_regs[CFG_X_NORM_A]);
        xnb = $signed(shadow_regs[CFG_X_NORM_B]);
        xnc = $signed(shadow_regs[CFG_X_NORM_C]);
        ok = 1'b1;
        // z slab
        az = (pz < 0) ? -pz : pz;
        if (az - hz >= -HALF_TOLERANCE && !((pz < 0 && vz > 0) || (pz > 0 && vz < 0)))
            ok = 1'b0;
        if (vz == 0)
        begin
            tmin = 64'sh8000_0000_0000_0000;
            tmax = 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            dz = (vz > 0) ? hz : -hz;
            tmin = cross_t(-(pz + dz), vz);
            tmax = cross_t(-(pz - dz), vz);
        end
        // y faces then x faces
        cy = dot_q30(0, ynb, ync, vx, vy, vz);
        dy = dot_q30(0, ynb, ync, px, py, pz);
        if (ok) ok = clip_face(yoff + dy, cy, tmin, tmax);
        if (ok) ok = clip_face(yoff - dy, -cy, tmin, tmax);
        cx = dot_q30(xna, xnb, xnc, vx, vy, vz);
        dx = dot_q30(xna, xnb, xnc, px, py, pz);
        if (ok) ok = clip_face(xoff + dx, cx, tmin, tmax);
        if (ok) ok = clip_face(xoff - dx, -cx, tmin, tmax);
        if (ok && tmax <= tmin + HALF_TOLERANCE)
            ok = 1'b0;
        res = '0;
        if (ok)
        begin
            d = (tmin < HALF_TOLERANCE) ? 0 : tmin;
            if (d > 64'sh7FFF_FFFF) d = 64'sh7FFF_FFFF;
            res.hit = 1'b1;
            res.distance = d[30:0];
        end
        return res;
    endfunction

    // write all eight registers back to back
    task automatic load_regs(input logic [31:0] v [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_wdata <= v[i];
            @(posedge clk);
            shadow_regs[i] = (i == CFG_HALF_Z) ? {1'b0, v[i][30:0]} : v[i];
        end
        cfg_we <= 1'b0;
    endtask

    // let every pending result arrive, then the pipeline empty out
    task automatic drain;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // offer one ray word and wait for it to be taken
    task automatic send_ray(input ray_word_t w);
        int gap;
        gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        if (gap != 0)
        begin
            ray_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ray_if.valid <= 1'b1;
        ray_if.data  <= w;
        do
            @(posedge clk);
        while (!ray_if.ready);
        pending_hits.push_back(entry_distance(w));
    endtask

    // lower valid once a burst of rays is over
    task automatic stop_rays;
        ray_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_unit();
        return $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
    endfunction

    function automatic logic [31:0] rnd_near(int span);
        return $urandom_range(2 * span, 0) - span;
    endfunction

    // mostly rays near the solid, some full-range noise
    function automatic ray_word_t rnd_ray();
        ray_word_t w;
        if ($urandom_range(0, 9) == 0)
        begin
            w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return w;
        end
        w.pos_x = rnd_near(32'h4_0000);
        w.pos_y = rnd_near(32'h4_0000);
        w.pos_z = rnd_near(32'h4_0000);
        w.dir_x = rnd_unit();
        w.dir_y = rnd_unit();
        w.dir_z = rnd_unit();
        // axis-aligned or tiny components now and then
        case ($urandom_range(0, 7))
            0: w.dir_z = '0;
            1: w.dir_x = $urandom_range(64, 0) - 32;
            2: w.dir_y = '0;
            3: w.dir_z = $urandom_range(2048, 0) - 1024;
            default: ;
        endcase
        return w;
    endfunction

    // random in-range register setting, sizes of a few units
    task automatic rnd_regs;
        logic [31:0] v [8];
        v[CFG_Y_NORM_B] = rnd_unit();
        v[CFG_Y_NORM_C] = rnd_unit();
        v[CFG_Y_OFFSET] = -$urandom_range(32'h4_0000, 0);
        v[CFG_X_NORM_A] = rnd_unit();
        v[CFG_X_NORM_B] = rnd_unit();
        v[CFG_X_NORM_C] = rnd_unit();
        v[CFG_X_OFFSET] = -$urandom_range(32'h4_0000, 0);
        v[CFG_HALF_Z]   = $urandom_range(32'h4_0000, 0);
        load_regs(v);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_ray(rnd_ray());
        stop_rays();
    endtask

    // directed rays under the reset box
    task automatic test_directed;
        ray_word_t d [$];
        d.push_back({32'sd0, 32'sd0, 32'sd0, 32'sh4000_0000, 32'sd0, 32'sd0});
        d.push_back({-32'sh3_0000, 32'sd0, 32'sd0, 32'sh4000_0000, 32'sd0, 32'sd0});
        d.push_back({-32'sh3_0000, 32'sd0, 32'sd0, -32'sh4000_0000, 32'sd0, 32'sd0});
        d.push_back({32'sd0, 32'sh3_0000, 32'sd0, 32'sd0, -32'sh4000_0000, 32'sd0});
        d.push_back({32'sd0, 32'sd0, 32'sh3_0000, 32'sd0, 32'sd0, -32'sh4000_0000});
        d.push_back({32'sd0, 32'sd0, 32'sh3_0000, 32'sd0, 32'sd0, 32'sh4000_0000});
        // parallel to z, inside and outside
        d.push_back({32'sd0, 32'sd0, 32'sd0, 32'sh2d41_3ccd, 32'sh2d41_3ccd, 32'sd0});
        d.push_back({32'sd0, 32'sd0, 32'sh2_0000, 32'sh4000_0000, 32'sd0, 32'sd0});
        // tiny cosine and large distance
        d.push_back({-32'sh2_0000, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0});
        d.push_back({-32'sh2_0000, 32'sd0, 32'sd0, 32'sh4000, 32'sd0, 32'sh0});
        d.push_back({-32'sh7FFF_0000, 32'sd0, 32'sd0, 32'sh1_0000, 32'sd0, 32'sd0});
        // touching an edge and sitting on a face
        d.push_back({-32'sh2_0000, 32'sh1_0000, 32'sd0, 32'sh4000_0000, 32'sd0, 32'sd0});
        d.push_back({32'sh1_0000, 32'sd0, 32'sd0, 32'sh4000_0000, 32'sd0, 32'sd0});
        d.push_back({32'sh1_0000, 32'sd0, 32'sd0, -32'sh4000_0000, 32'sd0, 32'sd0});
        // field extremes
        d.push_back({32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000});
        d.push_back({32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     -32'sh4000_0000, -32'sh4000_0000, -32'sh4000_0000});
        d.push_back({32'sh8000_0000, 32'sd0, 32'sd0, 32'sh4000_0000, 32'sd0, 32'sd0});
        d.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        foreach (d[i])
            send_ray(d[i]);
        stop_rays();
        drain();
    endtask

    // several random box settings with idling
    task automatic test_random_boxes;
        for (int k = 0; k < 5; k++)
        begin
            rnd_regs();
            run_random(150);
            drain();
        end
    endtask

    // extreme and out-of-range register values
    task automatic test_extreme_regs;
        logic [31:0] hi [8];
        logic [31:0] lo [8];
        hi = '{32'h4000_0000, 32'h4000_0000, 32'h0000_0000, 32'h4000_0000,
               32'h4000_0000, 32'h4000_0000, 32'h0000_0000, 32'h7FFF_FFFF};
        lo = '{32'hC000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000,
               32'hC000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0000};
        load_regs(hi);
        run_random(100);
        drain();
        load_regs(lo);
        run_random(100);
        drain();
        hi = '{$urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        load_regs(hi);
        run_random(100);
        drain();
    endtask

    // long receiver hold-off while rays keep coming
    task automatic test_backpressure;
        rnd_regs();
        hold_long = 1'b1;
        run_random(200);
        drain();
    endtask

    // full-rate streaming at the end, no idling
    task automatic test_streaming;
        idle_on = 1'b0;
        rnd_regs();
        run_random(300);
    endtask

    // receiver ready with random stall bursts
    initial
    begin
        int stall;
        stall = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                res_if.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_long = 1'b0;
                res_if.ready <= 1'b1;
            end
            else if (stall != 0)
            begin
                stall--;
                res_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 19) - 1;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // compare each result word with the oldest pending one
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hit=%0d distance=%0d",
                             res_if.data.hit, res_if.data.distance);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (res_if.data.hit !== want.hit || res_if.data.distance !== want.distance)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit=%0d distance=%0d, got hit=%0d distance=%0d",
                                 want.hit, want.distance, res_if.data.hit, res_if.data.distance);
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int waited;
        mismatches    = 0;
        idle_on       = 1'b1;
        hold_long     = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_Y_NORM_B;
        cfg_wdata     = '0;
        ray_if.valid  = 1'b0;
        ray_if.data   = '0;
        shadow_regs   = '{32'hC000_0000, 32'h0, 32'hFFFF_0000, 32'hC000_0000,
                          32'h0, 32'h0, 32'hFFFF_0000, 32'h0001_0000};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_boxes();
        test_extreme_regs();
        test_backpressure();
        test_streaming();

        waited = 0;
        while (pending_hits.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_hits.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
